[src/keepalive_heartbeat_fsm_macros.svh]
// ----------------------------------------------------------------------------
// Keepalive heartbeat watchdog assertion macros
// Shared immediate-implication and next-cycle-implication property forms.
// ----------------------------------------------------------------------------
`ifndef KEEPALIVE_HEARTBEAT_FSM_MACROS_SVH
`define KEEPALIVE_HEARTBEAT_FSM_MACROS_SVH

// Antecedent implies consequent in the same cycle, quiet during reset.
`define KAHB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the following cycle, quiet during reset.
`define KAHB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/kahb_pkg.sv]
// ----------------------------------------------------------------------------
// kahb_pkg
// Types, codes and reset values shared by the keepalive watchdog modules.
// ----------------------------------------------------------------------------
package kahb_pkg;

	localparam int unsigned PeriodW = 16;
	localparam int unsigned ModeW   = 3;
	localparam int unsigned StatusW = 16;
	localparam int unsigned ActionW = 2;
	localparam int unsigned PhaseW  = 3;
	localparam int unsigned CfgIdxW = 3;

	// Event codes
	localparam logic [ModeW-1:0] ModeTick       = 3'd0;
	localparam logic [ModeW-1:0] ModeConnect    = 3'd1;
	localparam logic [ModeW-1:0] ModeAuth       = 3'd2;
	localparam logic [ModeW-1:0] ModeDisconnect = 3'd3;
	localparam logic [ModeW-1:0] ModePacket     = 3'd4;
	localparam logic [ModeW-1:0] ModePong       = 3'd5;

	// Commands to the client
	localparam logic [ActionW-1:0] ActNone      = 2'd0;
	localparam logic [ActionW-1:0] ActPing      = 2'd1;
	localparam logic [ActionW-1:0] ActLeave     = 2'd2;
	localparam logic [ActionW-1:0] ActReconnect = 2'd3;

	localparam logic [StatusW-1:0] NormalClose = 16'd1000;

	// Register indexes on the configuration port
	localparam logic [CfgIdxW-1:0] CfgConnect = 3'd0;
	localparam logic [CfgIdxW-1:0] CfgAuth    = 3'd1;
	localparam logic [CfgIdxW-1:0] CfgIdle    = 3'd2;
	localparam logic [CfgIdxW-1:0] CfgPong    = 3'd3;
	localparam logic [CfgIdxW-1:0] CfgRetry   = 3'd4;

	localparam logic [PeriodW-1:0] ConnectReset = 16'd20000;
	localparam logic [PeriodW-1:0] AuthReset    = 16'd5000;
	localparam logic [PeriodW-1:0] IdleReset    = 16'd20000;
	localparam logic [PeriodW-1:0] PongReset    = 16'd15000;
	localparam logic [PeriodW-1:0] RetryReset   = 16'd2000;

	typedef struct packed {
		logic [PeriodW-1:0] connect_timeout_ms;
		logic [PeriodW-1:0] auth_timeout_ms;
		logic [PeriodW-1:0] idle_period_ms;
		logic [PeriodW-1:0] pong_timeout_ms;
		logic [PeriodW-1:0] retry_period_ms;
	} cfg_t;

	typedef struct packed {
		logic [ModeW-1:0]   mode;
		logic [StatusW-1:0] close_status;
		logic               packet_is_reply;
	} event_t;

	typedef struct packed {
		logic [ActionW-1:0] action;
		logic [PhaseW-1:0]  phase_now;
		logic               timer_running;
	} result_t;

endpackage

[src/kahb_cfg_regs.sv]
// ----------------------------------------------------------------------------
// kahb_cfg_regs
// Holds the five timer periods and takes writes from the configuration port.
// ----------------------------------------------------------------------------
module kahb_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [kahb_pkg::CfgIdxW-1:0]     wr_index,
	input  logic [kahb_pkg::PeriodW-1:0]     wr_data,
	output kahb_pkg::cfg_t                   cfg
);

	kahb_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.connect_timeout_ms <= kahb_pkg::ConnectReset;
			cfg_q.auth_timeout_ms    <= kahb_pkg::AuthReset;
			cfg_q.idle_period_ms     <= kahb_pkg::IdleReset;
			cfg_q.pong_timeout_ms    <= kahb_pkg::PongReset;
			cfg_q.retry_period_ms    <= kahb_pkg::RetryReset;
		end else if (wr_en) begin
			// Writes to an index beyond the register list are dropped.
			case (wr_index)
				kahb_pkg::CfgConnect: cfg_q.connect_timeout_ms <= wr_data;
				kahb_pkg::CfgAuth:    cfg_q.auth_timeout_ms    <= wr_data;
				kahb_pkg::CfgIdle:    cfg_q.idle_period_ms     <= wr_data;
				kahb_pkg::CfgPong:    cfg_q.pong_timeout_ms    <= wr_data;
				kahb_pkg::CfgRetry:   cfg_q.retry_period_ms    <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[src/kahb_core.sv]
// ----------------------------------------------------------------------------
// kahb_core
// Phase machine, repeating millisecond timer and peer flag of the watchdog.
// ----------------------------------------------------------------------------
`include "keepalive_heartbeat_fsm_macros.svh"

module kahb_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  kahb_pkg::event_t  evt,
	input  kahb_pkg::cfg_t    cfg,
	output kahb_pkg::result_t res
);

	typedef enum logic [kahb_pkg::PhaseW-1:0] {
		PH_IDLE         = 3'd0,
		PH_WAIT_CONNECT = 3'd1,
		PH_WAIT_AUTH    = 3'd2,
		PH_WAIT_PONG    = 3'd3,
		PH_RECONNECT    = 3'd4
	} phase_t;

	phase_t                       phase_q, phase_d;
	logic                         timer_q, timer_d;
	logic [kahb_pkg::PeriodW-1:0] elapsed_q, elapsed_d;
	logic                         peer_q, peer_d;
	logic [kahb_pkg::ActionW-1:0] action;
	logic [kahb_pkg::PeriodW-1:0] period;
	logic [kahb_pkg::PeriodW:0]   elapsed_inc;
	logic                         expired;

	always_comb begin
		case (phase_q)
			PH_WAIT_CONNECT: period = cfg.connect_timeout_ms;
			PH_WAIT_AUTH:    period = cfg.auth_timeout_ms;
			PH_WAIT_PONG:    period = cfg.pong_timeout_ms;
			PH_RECONNECT:    period = cfg.retry_period_ms;
			default:         period = cfg.idle_period_ms;
		endcase
	end

	// A period of zero expires on every tick, like a period of one.
	assign elapsed_inc = {1'b0, elapsed_q} + {{kahb_pkg::PeriodW{1'b0}}, 1'b1};
	assign expired     = elapsed_inc >= {1'b0, period};

	always_comb begin
		phase_d   = phase_q;
		timer_d   = timer_q;
		elapsed_d = elapsed_q;
		peer_d    = peer_q;
		action    = kahb_pkg::ActNone;
		case (evt.mode)
			kahb_pkg::ModeTick: begin
				if (timer_q) begin
					if (expired) begin
						elapsed_d = '0;
						if (peer_q) begin
							case (phase_q)
								PH_IDLE: begin
									phase_d = PH_WAIT_PONG;
									action  = kahb_pkg::ActPing;
								end
								PH_RECONNECT: action = kahb_pkg::ActReconnect;
								default:      action = kahb_pkg::ActLeave;
							endcase
						end
					end else begin
						elapsed_d = elapsed_inc[kahb_pkg::PeriodW-1:0];
					end
				end
			end
			kahb_pkg::ModeConnect: begin
				peer_d    = 1'b1;
				phase_d   = PH_WAIT_CONNECT;
				timer_d   = 1'b1;
				elapsed_d = '0;
			end
			kahb_pkg::ModeAuth: begin
				phase_d   = PH_WAIT_AUTH;
				timer_d   = 1'b1;
				elapsed_d = '0;
			end
			kahb_pkg::ModeDisconnect: begin
				// A normal close stops the timer, clears the elapsed time and keeps the phase.
				elapsed_d = '0;
				if (evt.close_status != kahb_pkg::NormalClose) begin
					phase_d = PH_RECONNECT;
					timer_d = 1'b1;
				end else begin
					timer_d = 1'b0;
				end
			end
			kahb_pkg::ModePacket: begin
				if (evt.packet_is_reply) begin
					phase_d   = PH_IDLE;
					timer_d   = 1'b1;
					elapsed_d = '0;
				end
			end
			kahb_pkg::ModePong: begin
				phase_d   = PH_IDLE;
				timer_d   = 1'b1;
				elapsed_d = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			timer_q   <= 1'b0;
			elapsed_q <= '0;
			peer_q    <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			timer_q   <= timer_d;
			elapsed_q <= elapsed_d;
			peer_q    <= peer_d;
		end
	end

	assign res.action        = action;
	assign res.phase_now     = phase_d;
	assign res.timer_running = timer_d;

	`KAHB_ASSERT_IMP(a_stopped_timer_clear, !timer_q, elapsed_q == '0, "stopped timer has elapsed time")
	`KAHB_ASSERT_IMP(a_action_only_on_tick, step && (evt.mode != kahb_pkg::ModeTick), action == kahb_pkg::ActNone, "command issued outside a tick")
	`KAHB_ASSERT_NXT(a_ping_enters_pong, step && (action == kahb_pkg::ActPing), (phase_q == PH_WAIT_PONG) && timer_q && (elapsed_q == '0), "ping did not restart in wait-pong")
	`KAHB_ASSERT_IMP(a_action_needs_peer, action != kahb_pkg::ActNone, peer_q && timer_q, "command without known peer or running timer")

endmodule

[src/keepalive_heartbeat_fsm.sv]
// Each accepted event is held in the event register, and its result in the result register.
// Throughput: one event per cycle unless a stalled result fills the pipeline; the phase,
// timer and peer update is a single registered pass between the event and result registers.
// Reset (arst_n, asynchronous): phase idle, timer stopped, elapsed time zero,
// peer unknown, periods back to their defaults, both pipeline stages empty.
// ----------------------------------------------------------------------------
// keepalive_heartbeat_fsm
// Connection keepalive watchdog: turns tick, connect, auth, disconnect, packet
// and pong events into ping, leave and reconnect commands.
// ----------------------------------------------------------------------------
module keepalive_heartbeat_fsm (
	input  logic                          clk,
	input  logic                          arst_n,
	// Event channel
	input  logic                          event_valid,
	output logic                          event_stall,
	input  logic [kahb_pkg::ModeW-1:0]    mode,
	input  logic [kahb_pkg::StatusW-1:0]  close_status,
	input  logic                          packet_is_reply,
	// Result channel
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [kahb_pkg::ActionW-1:0]  action,
	output logic [kahb_pkg::PhaseW-1:0]   phase_now,
	output logic                          timer_running,
	// Configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kahb_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [kahb_pkg::PeriodW-1:0]  cfg_data
);

	logic              valid_s1;
	kahb_pkg::event_t  evt_s1;
	logic              valid_s2;
	kahb_pkg::result_t res_s2;
	kahb_pkg::result_t res_next;
	kahb_pkg::cfg_t    cfg;
	logic              advance;

	// The event register moves on whenever the result register is free or
	// its transaction completes in this cycle.
	assign advance     = valid_s1 && (!valid_s2 || !result_stall);
	assign event_stall = valid_s1 && !advance;
	assign cfg_ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!event_stall) begin
			valid_s1 <= event_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (event_valid && !event_stall) begin
			evt_s1.mode            <= mode;
			evt_s1.close_status    <= close_status;
			evt_s1.packet_is_reply <= packet_is_reply;
		end
	end

	kahb_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	kahb_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.evt    (evt_s1),
		.cfg    (cfg),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign result_valid  = valid_s2;
	assign action        = res_s2.action;
	assign phase_now     = res_s2.phase_now;
	assign timer_running = res_s2.timer_running;

endmodule

[bench/kahb_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kahb_checker
// Watches the event, result and configuration channels of the keepalive
// watchdog, predicts each result from its own copy of the phase, timer, peer
// flag and periods, and compares every result transaction field by field.
// ----------------------------------------------------------------------------
module kahb_checker
	import kahb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 event_valid,
	input  logic                 event_stall,
	input  logic [ModeW-1:0]     mode,
	input  logic [StatusW-1:0]   close_status,
	input  logic                 packet_is_reply,
	input  logic                 result_valid,
	input  logic                 result_stall,
	input  logic [ActionW-1:0]   action,
	input  logic [PhaseW-1:0]    phase_now,
	input  logic                 timer_running,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CfgIdxW-1:0]   cfg_index,
	input  logic [PeriodW-1:0]   cfg_data,
	output int                   mismatches,
	output int                   results_owed
);

	typedef enum logic [PhaseW-1:0] {
		PhIdle        = 3'd0,
		PhWaitConnect = 3'd1,
		PhWaitAuth    = 3'd2,
		PhWaitPong    = 3'd3,
		PhReconnect   = 3'd4
	} phase_e;

	cfg_t               periods;
	phase_e             cur_phase;
	logic               timer_on;
	logic [PeriodW-1:0] elapsed_ms;
	logic               peer_seen;
	result_t            due_results[$];

	function automatic void restart_timer(input phase_e next);
		cur_phase  = next;
		timer_on   = 1'b1;
		elapsed_ms = '0;
	endfunction

	// Applies one event to the watchdog state and returns what it reports.
	function automatic result_t heartbeat_step(input event_t ev);
		result_t          res;
		logic [PeriodW:0] next_ms;
		logic [PeriodW:0] limit;
		res.action = ActNone;
		case (cur_phase)
			PhWaitConnect: limit = {1'b0, periods.connect_timeout_ms};
			PhWaitAuth:    limit = {1'b0, periods.auth_timeout_ms};
			PhWaitPong:    limit = {1'b0, periods.pong_timeout_ms};
			PhReconnect:   limit = {1'b0, periods.retry_period_ms};
			default:       limit = {1'b0, periods.idle_period_ms};
		endcase
		case (ev.mode)
			ModeTick: begin
				if (timer_on) begin
					next_ms = {1'b0, elapsed_ms} + 1'b1;
					if (next_ms >= limit) begin
						// The timer repeats; a fire only matters once a peer is known.
						elapsed_ms = '0;
						if (peer_seen) begin
							if (cur_phase == PhIdle) begin
								restart_timer(PhWaitPong);
								res.action = ActPing;
							end else if (cur_phase == PhReconnect) begin
								res.action = ActReconnect;
							end else begin
								res.action = ActLeave;
							end
						end
					end else begin
						elapsed_ms = next_ms[PeriodW-1:0];
					end
				end
			end
			ModeConnect: begin
				peer_seen = 1'b1;
				restart_timer(PhWaitConnect);
			end
			ModeAuth: restart_timer(PhWaitAuth);
			ModeDisconnect: begin
				timer_on   = 1'b0;
				elapsed_ms = '0;
				if (ev.close_status != NormalClose)
					restart_timer(PhReconnect);
			end
			ModePacket: begin
				if (ev.packet_is_reply)
					restart_timer(PhIdle);
			end
			ModePong: restart_timer(PhIdle);
			default: ;
		endcase
		res.phase_now     = cur_phase;
		res.timer_running = timer_on;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		event_t  ev;
		if (!arst_n) begin
			periods.connect_timeout_ms = ConnectReset;
			periods.auth_timeout_ms    = AuthReset;
			periods.idle_period_ms     = IdleReset;
			periods.pong_timeout_ms    = PongReset;
			periods.retry_period_ms    = RetryReset;
			cur_phase    = PhIdle;
			timer_on     = 1'b0;
			elapsed_ms   = '0;
			peer_seen    = 1'b0;
			mismatches   = 0;
			results_owed = 0;
			due_results.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CfgConnect: periods.connect_timeout_ms = cfg_data;
					CfgAuth:    periods.auth_timeout_ms    = cfg_data;
					CfgIdle:    periods.idle_period_ms     = cfg_data;
					CfgPong:    periods.pong_timeout_ms    = cfg_data;
					CfgRetry:   periods.retry_period_ms    = cfg_data;
					default: ;
				endcase
			end
			if (result_valid && !result_stall) begin
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result transaction, action %0d phase %0d timer %0d",
						$time, action, phase_now, timer_running);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					if (action !== want.action) begin
						$display("%0t: action expected %0d, actual %0d", $time, want.action, action);
						mismatches++;
					end
					if (phase_now !== want.phase_now) begin
						$display("%0t: phase_now expected %0d, actual %0d",
							$time, want.phase_now, phase_now);
						mismatches++;
					end
					if (timer_running !== want.timer_running) begin
						$display("%0t: timer_running expected %0d, actual %0d",
							$time, want.timer_running, timer_running);
						mismatches++;
					end
				end
			end
			if (event_valid && !event_stall) begin
				ev.mode            = mode;
				ev.close_status    = close_status;
				ev.packet_is_reply = packet_is_reply;
				due_results.push_back(heartbeat_step(ev));
			end
			results_owed = due_results.size();
		end
	end

endmodule

[bench/tb_keepalive_heartbeat_fsm.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keepalive_heartbeat_fsm
// Drives directed and random event sequences through the keepalive watchdog
// under several period settings and idling patterns, including a long
// receiver hold-off, and reports the verdict given by the checker.
// ----------------------------------------------------------------------------
module tb_keepalive_heartbeat_fsm;
	import kahb_pkg::*;

	// Event codes the block has no use for.
	localparam logic [ModeW-1:0] ModeSpareLo = 3'd6;
	localparam logic [ModeW-1:0] ModeSpareHi = 3'd7;
	localparam int unsigned RandomPerPhase = 250;
	localparam int unsigned HoldCycles     = 64;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 event_valid = 1'b0;
	logic                 event_stall;
	logic [ModeW-1:0]     mode = ModeTick;
	logic [StatusW-1:0]   close_status = '0;
	logic                 packet_is_reply = 1'b0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic [ActionW-1:0]   action;
	logic [PhaseW-1:0]    phase_now;
	logic                 timer_running;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CfgIdxW-1:0]   cfg_index = CfgConnect;
	logic [PeriodW-1:0]   cfg_data = '0;

	int                   mismatches;
	int                   results_owed;
	int unsigned          gap_pct = 0;
	int unsigned          stall_pct = 0;
	logic                 hold_req = 1'b0;
	logic                 hold_done = 1'b0;
	int unsigned          hold_left = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	keepalive_heartbeat_fsm i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.event_valid     (event_valid),
		.event_stall     (event_stall),
		.mode            (mode),
		.close_status    (close_status),
		.packet_is_reply (packet_is_reply),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.action          (action),
		.phase_now       (phase_now),
		.timer_running   (timer_running),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	kahb_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.event_valid     (event_valid),
		.event_stall     (event_stall),
		.mode            (mode),
		.close_status    (close_status),
		.packet_is_reply (packet_is_reply),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.action          (action),
		.phase_now       (phase_now),
		.timer_running   (timer_running),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatches      (mismatches),
		.results_owed    (results_owed)
	);

	// Result side: random stalls, plus one long hold-off when requested so that
	// the block backs up and stalls the event channel.
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_left = HoldCycles;
			hold_done = 1'b1;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic event_t make_event(input logic [ModeW-1:0] m,
		input logic [StatusW-1:0] status, input logic reply);
		event_t ev;
		ev.mode            = m;
		ev.close_status    = status;
		ev.packet_is_reply = reply;
		return ev;
	endfunction

	// Ticks dominate so that the short periods expire often; the other events
	// walk the watchdog through its session phases.
	function automatic event_t random_event();
		event_t      ev;
		int unsigned pick;
		pick = $urandom_range(99);
		ev = make_event(ModeTick, 16'($urandom), 1'($urandom));
		if (pick < 50)
			ev.mode = ModeTick;
		else if (pick < 58)
			ev.mode = ModeConnect;
		else if (pick < 64)
			ev.mode = ModeAuth;
		else if (pick < 73) begin
			ev.mode = ModeDisconnect;
			case ($urandom_range(3))
				0, 1: ev.close_status = NormalClose;
				2:    ev.close_status = NormalClose + 16'($urandom_range(2)) - 1'b1;
				default: ;
			endcase
		end else if (pick < 85)
			ev.mode = ModePacket;
		else if (pick < 95)
			ev.mode = ModePong;
		else
			ev.mode = $urandom_range(1) ? ModeSpareLo : ModeSpareHi;
		return ev;
	endfunction

	task automatic send_event(input event_t ev);
		while ($urandom_range(99) < gap_pct) begin
			event_valid <= 1'b0;
			@(posedge clk);
		end
		event_valid     <= 1'b1;
		mode            <= ev.mode;
		close_status    <= ev.close_status;
		packet_is_reply <= ev.packet_is_reply;
		do @(posedge clk); while (event_stall);
	endtask

	// Writes all five periods in order, then one write to a random index past the last register.
	task automatic load_periods(input logic [PeriodW-1:0] p [5]);
		logic [CfgIdxW-1:0] reg_order [5];
		reg_order = '{CfgConnect, CfgAuth, CfgIdle, CfgPong, CfgRetry};
		for (int i = 0; i < 6; i++) begin
			cfg_valid <= 1'b1;
			if (i < 5) begin
				cfg_index <= reg_order[i];
				cfg_data  <= p[i];
			end else begin
				cfg_index <= CfgRetry + CfgIdxW'($urandom_range(1, 3));
				cfg_data  <= 16'($urandom);
			end
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		do @(negedge clk); while (results_owed != 0);
		@(posedge clk);
	endtask

	initial begin
		logic [PeriodW-1:0] periods [5];
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Short periods, with idle at zero so that it expires on every tick.
		load_periods('{16'd2, 16'd1, 16'd0, 16'd3, 16'd1});
		send_event(make_event(ModeTick, 16'h0000, 1'b0));
		send_event(make_event(ModePong, 16'hffff, 1'b1));
		send_event(make_event(ModeTick, 16'h0000, 1'b0));
		send_event(make_event(ModePacket, 16'h0000, 1'b0));
		send_event(make_event(ModeSpareLo, 16'hffff, 1'b1));
		send_event(make_event(ModeSpareHi, 16'h0000, 1'b0));
		send_event(make_event(ModeConnect, 16'h0000, 1'b0));
		send_event(make_event(ModeTick, 16'h0000, 1'b0));
		send_event(make_event(ModeTick, 16'h0000, 1'b0));
		send_event(make_event(ModeAuth, 16'h0000, 1'b0));
		send_event(make_event(ModeTick, 16'h0000, 1'b0));
		send_event(make_event(ModePacket, 16'h0000, 1'b1));
		send_event(make_event(ModeTick, 16'h0000, 1'b0));
		send_event(make_event(ModeTick, 16'h0000, 1'b0));
		send_event(make_event(ModeTick, 16'h0000, 1'b0));
		send_event(make_event(ModeTick, 16'h0000, 1'b0));
		send_event(make_event(ModeDisconnect, NormalClose, 1'b0));
		send_event(make_event(ModeTick, 16'h0000, 1'b0));
		send_event(make_event(ModeDisconnect, 16'hffff, 1'b0));
		send_event(make_event(ModeTick, 16'h0000, 1'b0));
		send_event(make_event(ModeDisconnect, 16'h0000, 1'b0));
		send_event(make_event(ModeTick, 16'h0000, 1'b0));
		send_event(make_event(ModePong, 16'h0000, 1'b0));
		send_event(make_event(ModeConnect, 16'hffff, 1'b1));
		event_valid <= 1'b0;
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			foreach (periods[i])
				periods[i] = PeriodW'($urandom_range(1, 6));
			// Two settings hold the extremes, with zero and full-scale periods.
			if (ph == 1)
				periods = '{16'hffff, 16'd0, 16'd1, 16'hffff, 16'd0};
			else if (ph == 3)
				periods = '{16'd0, 16'hffff, 16'hffff, 16'd1, 16'hffff};
			load_periods(periods);
			case (ph)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 78; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 78; end
				3: begin gap_pct = 37; stall_pct = 37; end
				default: begin
					gap_pct   = 0;
					stall_pct = 0;
					hold_req  = 1'b1;
				end
			endcase
			repeat (RandomPerPhase)
				send_event(random_event());
			event_valid <= 1'b0;
			drain();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0 && results_owed == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
